/* design/lmat_pkg.sv */
// shared types and constants for the local mean adaptive threshold block
// no dependencies; imported by every module of the block except lmat_fifo
`timescale 1ns / 1ps
`default_nettype none

package lmat_pkg;

  // widest column index and line ring pointer any parameter setting can need
  localparam int COL_MAX_W  = 12;
  localparam int RING_MAX_W = 5;
  localparam int MAX_HEIGHT = 1024;

  // register map, index = byte address / 4
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS       = 2'd2;
  localparam logic [1:0] REG_FACTOR       = 2'd3;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       was_zeroed;
    logic       frame_last;
  } out_item_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [2:0]  n;
    logic [9:0]  factor;
  } cfg_t;

  // one classified transaction handed from front to back
  typedef struct packed {
    logic                  wr;
    logic [7:0]            pix;
    logic [COL_MAX_W-1:0]  col;
    logic [RING_MAX_W-1:0] wr_row;
    logic                  ir_zero;
    logic                  old_en;
    logic [RING_MAX_W-1:0] old_row;
    logic                  col_first;
    logic                  col_sub;
    logic                  emit;
    logic [RING_MAX_W-1:0] out_row;
    logic [COL_MAX_W-1:0]  out_col;
    logic                  interior;
    logic                  last;
    logic                  fwd;
  } cmd_t;

endpackage

`default_nettype wire

/* design/lmat_fifo.sv */
// small register queue with count, used between front and back and for results
// depends on nothing; DEPTH must be a power of two
`timescale 1ns / 1ps
`default_nettype none

module lmat_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic                            full,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                rdata,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

`default_nettype wire

/* design/lmat_front.sv */
// front end: accepts pixel and flush transactions, tracks frame position
// depends on lmat_pkg; emits one cmd_t per transaction that needs back-end work
`timescale 1ns / 1ps
`default_nettype none

module lmat_front import lmat_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     restart,
  input  wire cfg_t     cfg,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          cmd_push,
  output cmd_t          cmd
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RING   = 2 * MAX_RADIUS + 2;
  localparam int RING_W = $clog2(RING);

  logic [9:0]        ir, ir_c;
  logic [COL_W-1:0]  ic, ic_c;
  logic [RING_W-1:0] ir_ring, ir_ring_c;
  logic [9:0]        orow, orow_c;
  logic [COL_W-1:0]  ocol, ocol_c;
  logic [RING_W-1:0] or_ring, or_ring_c;
  logic [13:0]       pend, pend_c;
  logic              frame_done;

  logic              is_pixel;
  logic              new_frame;
  logic              emit;
  logic [13:0]       lag;
  logic [3:0]        two_n;
  logic [3:0]        side;
  logic [RING_W:0]   old_t;
  logic [RING_W-1:0] old_row;
  logic [COL_W:0]    ic_inc;
  logic [10:0]       ir_inc;
  logic [COL_W:0]    oc_inc;
  logic [10:0]       or_inc;
  logic              row_wrap, frame_wrap;
  logic              orow_wrap, oframe_wrap;
  logic              interior;
  logic              last;

  always_comb begin
    is_pixel  = (item.mode == MODE_PIXEL);
    new_frame = is_pixel && frame_done;
    ir_c      = new_frame ? '0 : ir;
    ic_c      = new_frame ? '0 : ic;
    ir_ring_c = new_frame ? '0 : ir_ring;
    orow_c    = new_frame ? '0 : orow;
    ocol_c    = new_frame ? '0 : ocol;
    or_ring_c = new_frame ? '0 : or_ring;
    pend_c    = new_frame ? '0 : pend;

    lag   = ({11'd0, cfg.n} * {3'd0, cfg.width}) + {11'd0, cfg.n};
    two_n = {cfg.n, 1'b0};
    side  = two_n + 4'd1;

    // ring slot of the row that drops out of the column sums
    old_t   = {1'b0, ir_ring_c} + (RING_W+1)'(RING) - (RING_W+1)'(side);
    old_row = (old_t >= (RING_W+1)'(RING)) ? RING_W'(old_t - (RING_W+1)'(RING))
                                           : RING_W'(old_t);

    emit = is_pixel ? (pend_c >= lag) : (frame_done && (pend != '0));

    interior = (13'(orow_c) >= 13'(cfg.n)) &&
               ((13'(orow_c) + 13'(cfg.n)) < 13'(cfg.height)) &&
               (13'(ocol_c) >= 13'(cfg.n)) &&
               ((13'(ocol_c) + 13'(cfg.n)) < 13'(cfg.width));
    last = (13'(orow_c) == 13'(cfg.height) - 13'd1) &&
           (13'(ocol_c) == 13'(cfg.width) - 13'd1);

    ic_inc     = {1'b0, ic_c} + 1'b1;
    ir_inc     = {1'b0, ir_c} + 11'd1;
    row_wrap   = (13'(ic_inc) >= 13'(cfg.width));
    frame_wrap = row_wrap && (ir_inc >= cfg.height);

    oc_inc      = {1'b0, ocol_c} + 1'b1;
    or_inc      = {1'b0, orow_c} + 11'd1;
    orow_wrap   = (13'(oc_inc) >= 13'(cfg.width));
    oframe_wrap = orow_wrap && (or_inc >= cfg.height);

    cmd_push = accept && (is_pixel || emit);

    cmd.wr        = is_pixel;
    cmd.pix       = item.pixel_in;
    cmd.col       = COL_MAX_W'(ic_c);
    cmd.wr_row    = RING_MAX_W'(ir_ring_c);
    cmd.ir_zero   = (ir_c == '0);
    cmd.old_en    = (11'(ir_c) > 11'(two_n));
    cmd.old_row   = RING_MAX_W'(old_row);
    cmd.col_first = (ic_c == '0);
    cmd.col_sub   = (13'(ic_c) > 13'(two_n));
    cmd.emit      = emit;
    cmd.out_row   = RING_MAX_W'(or_ring_c);
    cmd.out_col   = COL_MAX_W'(ocol_c);
    cmd.interior  = interior;
    cmd.last      = last;
    cmd.fwd       = (lag == '0);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ir <= '0; ic <= '0; ir_ring <= '0;
      orow <= '0; ocol <= '0; or_ring <= '0;
      pend <= '0; frame_done <= 1'b0;
    end else if (accept && (is_pixel || emit)) begin
      if (is_pixel) begin
        frame_done <= frame_wrap;
        if (!row_wrap) begin
          ic <= ic_inc[COL_W-1:0];
          ir <= ir_c; ir_ring <= ir_ring_c;
        end else if (frame_wrap) begin
          ic <= '0; ir <= '0; ir_ring <= '0;
        end else begin
          ic <= '0;
          ir <= ir_inc[9:0];
          ir_ring <= (ir_ring_c == RING_W'(RING - 1)) ? '0 : ir_ring_c + 1'b1;
        end
        pend <= emit ? pend_c : pend_c + 14'd1;
      end else begin
        pend <= pend - 14'd1;
      end
      if (emit) begin
        if (!orow_wrap) begin
          ocol <= oc_inc[COL_W-1:0];
          orow <= orow_c; or_ring <= or_ring_c;
        end else if (oframe_wrap) begin
          ocol <= '0; orow <= '0; or_ring <= '0;
        end else begin
          ocol <= '0;
          orow <= or_inc[9:0];
          or_ring <= (or_ring_c == RING_W'(RING - 1)) ? '0 : or_ring_c + 1'b1;
        end
      end else begin
        ocol <= ocol_c; orow <= orow_c; or_ring <= or_ring_c;
      end
    end
  end

endmodule

`default_nettype wire

/* design/lmat_back.sv */
// back end: line store, column sums, sliding window sum, threshold compare
// depends on lmat_pkg and lmat_fifo (result queue)
`timescale 1ns / 1ps
`default_nettype none

module lmat_back import lmat_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  cmd_empty,
  input  wire cmd_t  cmd,
  output logic       cmd_pop,
  input  wire logic  pop,
  output logic       empty,
  output out_item_t  result
);

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RING      = 2 * MAX_RADIUS + 2;
  localparam int RING_W    = $clog2(RING);
  localparam int SH_N      = 2 * MAX_RADIUS + 1;
  localparam int SH_IW     = $clog2(SH_N);
  localparam int OUT_DEPTH = 8;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  logic [7:0]  store  [RING][MAX_WIDTH];
  logic [11:0] colsum [MAX_WIDTH];
  logic [11:0] sh     [SH_N];

  // stage 1: memory data
  logic        s1_v;
  cmd_t        s1_cmd;
  logic [7:0]  rd_old, rd_pix;
  logic [11:0] col_rd, col_last;
  logic        fwd_hit;
  logic [11:0] newcol;
  // stage 2: window sum
  logic        s2_v;
  cmd_t        s2_cmd;
  logic [11:0] s2_col;
  logic [7:0]  s2_p;
  logic [15:0] wsum, wsum_next;
  // stage 3: multiply
  logic        s3_v, s3_emit, s3_int, s3_last;
  logic [7:0]  s3_p;
  logic [15:0] s3_sum;
  // stage 4: compare
  logic        s4_v, s4_emit, s4_int, s4_last;
  logic [7:0]  s4_p;
  logic [15:0] s4_lhs;
  logic [25:0] s4_rhs;

  logic [3:0]     side;
  logic [7:0]     area;
  logic [OCW-1:0] out_count;
  logic [OCW:0]   credit;
  logic           zeroed;
  out_item_t      res_in;
  logic           out_full;

  assign side   = {cfg.n, 1'b0} + 4'd1;
  assign area   = 8'({4'd0, side} * {4'd0, side});
  assign credit = {1'b0, out_count} + (OCW+1)'(s1_v) + (OCW+1)'(s2_v)
                  + (OCW+1)'(s3_v) + (OCW+1)'(s4_v);
  assign cmd_pop = !cmd_empty && (credit < (OCW+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd.wr) store[cmd.wr_row[RING_W-1:0]][cmd.col[COL_W-1:0]] <= cmd.pix;
      rd_old <= store[cmd.old_row[RING_W-1:0]][cmd.col[COL_W-1:0]];
      rd_pix <= store[cmd.out_row[RING_W-1:0]][cmd.out_col[COL_W-1:0]];
      col_rd <= colsum[cmd.col[COL_W-1:0]];
    end
  end

  always_comb begin
    newcol = (s1_cmd.ir_zero ? 12'd0 : (fwd_hit ? col_last : col_rd))
             + {4'd0, s1_cmd.pix} - (s1_cmd.old_en ? {4'd0, rd_old} : 12'd0);
    wsum_next = s2_cmd.col_first ? {4'd0, s2_col}
              : wsum + {4'd0, s2_col}
                - (s2_cmd.col_sub ? {4'd0, sh[SH_IW'({cfg.n, 1'b0})]} : 16'd0);
  end

  always_ff @(posedge clk) begin
    if (s1_v && s1_cmd.wr) begin
      colsum[s1_cmd.col[COL_W-1:0]] <= newcol;
      col_last <= newcol;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd  <= cmd;
      fwd_hit <= s1_v && s1_cmd.wr && (s1_cmd.col == cmd.col);
    end
    s2_cmd <= s1_cmd;
    s2_col <= newcol;
    s2_p   <= s1_cmd.fwd ? s1_cmd.pix : rd_pix;
    if (s2_v && s2_cmd.wr) begin
      wsum  <= wsum_next;
      sh[0] <= s2_col;
      for (int k = 1; k < SH_N; k++) sh[k] <= sh[k-1];
    end
    s3_emit <= s2_cmd.emit;
    s3_int  <= s2_cmd.interior;
    s3_last <= s2_cmd.last;
    s3_p    <= s2_p;
    s3_sum  <= s2_cmd.wr ? wsum_next : wsum;
    s4_emit <= s3_emit;
    s4_int  <= s3_int;
    s4_last <= s3_last;
    s4_p    <= s3_p;
    s4_lhs  <= {8'd0, s3_p} * {8'd0, area};
    s4_rhs  <= {16'd0, cfg.factor} * {10'd0, s3_sum};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0;
    end else begin
      s1_v <= cmd_pop;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  assign zeroed = s4_int && ({2'b0, s4_lhs, 8'd0} < s4_rhs);
  assign res_in = '{pixel_out: zeroed ? 8'd0 : s4_p, was_zeroed: zeroed,
                    frame_last: s4_last};

  lmat_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (s4_v && s4_emit),
    .wdata (res_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

  // credit keeps the queue from ever filling under a push
  logic unused_full;
  assign unused_full = out_full;

endmodule

`default_nettype wire

/* design/local_mean_adaptive_threshold.sv */
// latency: a result leaves window_radius*frame_width+window_radius transactions after
//   its pixel, then passes through the command queue and the four-stage back pipeline
// throughput: one transaction per clock while the command queue has room and the back
//   pipeline holds credit against the eight-entry result queue
// reset: synchronous, clears queues, frame position and registers to defaults;
//   line store and column sums are not cleared and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module local_mean_adaptive_threshold import lmat_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // pixel / flush transactions
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    pixel_item,
  // result transactions
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        result,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CMD_DEPTH = 4;

  // raw configuration registers
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [2:0]  window_radius;
  logic [9:0]  threshold_factor;
  logic        cfg_wr;
  cfg_t        cfg;

  // command queue between front and back
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd_in, cmd_out;
  logic        cmd_full, cmd_empty, cmd_pop;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // any register write restarts the frame in the front end
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= 11'd640;
      frame_height     <= 11'd480;
      window_radius    <= 3'd6;
      threshold_factor <= 10'd128;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  frame_width      <= pwdata[10:0];
        REG_FRAME_HEIGHT: frame_height     <= pwdata[10:0];
        REG_RADIUS:       window_radius    <= pwdata[2:0];
        REG_FACTOR:       threshold_factor <= pwdata[9:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = {21'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {21'd0, frame_height};
      REG_RADIUS:       prdata = {29'd0, window_radius};
      REG_FACTOR:       prdata = {22'd0, threshold_factor};
      default:          prdata = '0;
    endcase
  end

  // clamp to the supported ranges
  always_comb begin
    cfg.width  = (frame_width == '0) ? 11'd1
               : ((frame_width > MAX_WIDTH) ? 11'(MAX_WIDTH) : frame_width);
    cfg.height = (frame_height == '0) ? 11'd1
               : ((frame_height > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : frame_height);
    cfg.n      = (window_radius > MAX_RADIUS) ? 3'(MAX_RADIUS) : window_radius;
    cfg.factor = threshold_factor;
  end

  // input side looks full whenever the command queue is
  assign full   = cmd_full;
  assign accept = push && !full;

  lmat_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_wr),
    .cfg      (cfg),
    .accept   (accept),
    .item     (pixel_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lmat_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  lmat_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

`ifndef SYNTHESIS
  // commands only come from accepted transactions
  a_cmd_from_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (push && !full && cmd_count != 3'($unsigned(CMD_DEPTH))))
    else $error("command pushed without an accepted transaction");

  // a flush never lands on an interior pixel
  a_flush_border: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && !cmd_in.wr) |-> (cmd_in.emit && !cmd_in.interior))
    else $error("flush command on interior pixel");

  // a zeroed result carries a zero pixel
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.was_zeroed) |-> (result.pixel_out == 8'd0))
    else $error("zeroed result with nonzero pixel");
`endif

endmodule

`default_nettype wire
